// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the status flag bank.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge, reset included.
`define SFBR_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property outside reset.
`define SFBR_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== hdl/sfbr_pkg.sv =====
// Shared constants, codes and word types of the status flag bank.
// No dependencies.
`timescale 1ns / 1ps

package sfbr_pkg;

   localparam int BANK_COUNT  = 16;
   localparam int CLASS_COUNT = 3;
   localparam int RESULT_CAP  = 16;
   localparam int BIT_W       = 4;
   localparam int BANK_W      = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int ADDR_W      = BANK_W + 2;
   localparam int SNAP_COUNT  = (BANK_COUNT < RESULT_CAP) ? BANK_COUNT : RESULT_CAP;
   localparam int CNT_W       = $clog2(SNAP_COUNT + 1);
   localparam int NZ_W        = $clog2(BANK_COUNT + 1);

   localparam logic [15:0] NO_ID         = 16'hFFFF;
   localparam logic [1:0]  CLASS_INVALID = 2'd3;

   typedef enum logic [2:0] {
      REQ_SET        = 3'd0,
      REQ_CLEAR      = 3'd1,
      REQ_TEST_CLEAR = 3'd2,
      REQ_IS_SET     = 3'd3,
      REQ_ANY        = 3'd4,
      REQ_CLEAR_ALL  = 3'd5,
      REQ_READ_LAST  = 3'd6,
      REQ_SNAPSHOT   = 3'd7
   } req_kind_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_BANK  = 2'd1,
      ERR_CLASS = 2'd2,
      ERR_LEN   = 2'd3
   } err_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [1:0]        cls;
      logic [BANK_W-1:0] bank;
      logic [BIT_W-1:0]  bit_sel;
      logic [15:0]       id;
      logic [CNT_W-1:0]  count;
      err_type           err;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

   typedef struct packed {
      logic pop;
      logic wipe_busy;
   } back_ctrl_type;

   typedef struct packed {
      logic        flag_hit;
      logic [15:0] recent_id;
      logic [15:0] bank_word;
      logic [11:0] word_index;
      logic        final_item;
      err_type     error_code;
   } rsp_type;

endpackage

// ===== hdl/sfbr_front.sv =====
// Front end: accepts request words, checks class, bank and length, queues commands.
// Depends on sfbr_pkg.
`timescale 1ns / 1ps

module sfbr_front import sfbr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  logic [2:0]    req_type,
   input  logic [1:0]    req_status_class,
   input  logic [15:0]   req_flag_id,
   input  logic [15:0]   req_snapshot_len,
   input  back_ctrl_type back_ctrl,
   output cmd_link_type  cmd_link
);

   cmd_type      cmd_new;
   req_kind_type kind;
   logic [11:0]  bank_full;
   logic         bank_bad;
   logic         single;
   logic         push_ok;

   cmd_type      q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   always_comb begin
      kind      = req_kind_type'(req_type);
      bank_full = req_flag_id[15:BIT_W];
      bank_bad  = bank_full >= 12'(BANK_COUNT);
      single    = kind inside {REQ_SET, REQ_CLEAR, REQ_TEST_CLEAR, REQ_IS_SET};

      cmd_new.kind    = kind;
      cmd_new.cls     = req_status_class;
      cmd_new.bank    = bank_full[BANK_W-1:0];
      cmd_new.bit_sel = req_flag_id[BIT_W-1:0];
      cmd_new.id      = req_flag_id;
      cmd_new.count   = (req_snapshot_len >= 16'(SNAP_COUNT)) ? CNT_W'(SNAP_COUNT)
                                                              : req_snapshot_len[CNT_W-1:0];
      if (req_status_class == CLASS_INVALID) begin
         cmd_new.err = ERR_CLASS;
      end else if (single && bank_bad) begin
         cmd_new.err = ERR_BANK;
      end else if (kind == REQ_SNAPSHOT && req_snapshot_len == 16'd0) begin
         cmd_new.err = ERR_LEN;
      end else begin
         cmd_new.err = ERR_OK;
      end
   end

   assign req_full = (cnt_ff == 2'd2) || back_ctrl.wipe_busy;
   assign push_ok  = req_push && !req_full;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = back_ctrl.pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = 2'(cnt_ff + {1'b0, push_ok} - {1'b0, back_ctrl.pop});
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign cmd_link.valid = cnt_ff != 2'd0;
   assign cmd_link.cmd   = q_ff[rd_ptr_ff];

endmodule

// ===== hdl/sfbr_back.sv =====
// Back end: flag memory, last ids, nonzero counts and the command sequencer.
// Depends on sfbr_pkg.
`timescale 1ns / 1ps

module sfbr_back import sfbr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_link_type  cmd_link,
   output back_ctrl_type back_ctrl,
   input  logic          rsp_full,
   output logic          rsp_push,
   output rsp_type       rsp_item
);

   typedef enum logic [3:0] {
      ST_WIPE  = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EXEC  = 4'b0100,
      ST_CLEAR = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   cmd_type                            cmd_ff, cmd_in;
   logic [CNT_W-1:0]                   idx_ff, idx_in;
   logic [ADDR_W-1:0]                  wipe_ff, wipe_in;
   logic [CLASS_COUNT-1:0][15:0]       last_id_ff, last_id_in;
   logic [CLASS_COUNT-1:0][NZ_W-1:0]   nz_cnt_ff, nz_cnt_in;
   logic [15:0]                        rd_data_ff;
   logic [15:0]                        mem [1 << ADDR_W];

   logic              mem_re, mem_we;
   logic [ADDR_W-1:0] mem_raddr, mem_waddr;
   logic [15:0]       mem_wdata;
   logic              cls_ok;
   logic [15:0]       cur_id;
   logic [NZ_W-1:0]   cur_nz;
   logic [15:0]       mask;
   logic [15:0]       new_word;
   logic              is_last;
   logic              flag_write;

   always_comb begin
      cls_ok  = cmd_ff.err != ERR_CLASS;
      cur_id  = cls_ok ? last_id_ff[cmd_ff.cls] : NO_ID;
      cur_nz  = cls_ok ? nz_cnt_ff[cmd_ff.cls] : '0;
      mask    = 16'd1 << cmd_ff.bit_sel;
      is_last = (idx_ff + CNT_W'(1)) == cmd_ff.count;
      new_word = (cmd_ff.kind == REQ_SET) ? (rd_data_ff | mask) : (rd_data_ff & ~mask);

      state_in   = state_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      wipe_in    = wipe_ff;
      last_id_in = last_id_ff;
      nz_cnt_in  = nz_cnt_ff;
      mem_re     = 1'b0;
      mem_raddr  = '0;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = '0;
      flag_write = 1'b0;
      rsp_push   = 1'b0;
      back_ctrl.pop       = 1'b0;
      back_ctrl.wipe_busy = state_ff == ST_WIPE;

      rsp_item.flag_hit   = 1'b0;
      rsp_item.recent_id  = cur_id;
      rsp_item.bank_word  = 16'd0;
      rsp_item.word_index = 12'd0;
      rsp_item.final_item = 1'b1;
      rsp_item.error_code = cmd_ff.err;

      case (state_ff)
         ST_WIPE: begin
            mem_we    = 1'b1;
            mem_waddr = wipe_ff;
            wipe_in   = wipe_ff + ADDR_W'(1);
            if (wipe_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_link.valid) begin
               back_ctrl.pop = 1'b1;
               cmd_in        = cmd_link.cmd;
               idx_in        = '0;
               mem_re        = 1'b1;
               mem_raddr     = {cmd_link.cmd.cls,
                                (cmd_link.cmd.kind == REQ_SNAPSHOT) ? BANK_W'(0)
                                                                    : cmd_link.cmd.bank};
               wipe_in       = {cmd_link.cmd.cls, BANK_W'(0)};
               if (cmd_link.cmd.kind == REQ_CLEAR_ALL && cmd_link.cmd.err == ERR_OK) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = wipe_ff;
            wipe_in   = wipe_ff + ADDR_W'(1);
            if (wipe_ff[BANK_W-1:0] == BANK_W'(BANK_COUNT - 1)) begin
               nz_cnt_in[cmd_ff.cls] = '0;
               state_in              = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
               if (cmd_ff.err == ERR_OK) begin
                  case (cmd_ff.kind)
                     REQ_SET: begin
                        flag_write             = 1'b1;
                        last_id_in[cmd_ff.cls] = cmd_ff.id;
                        rsp_item.recent_id     = cmd_ff.id;
                     end
                     REQ_CLEAR: begin
                        flag_write = 1'b1;
                     end
                     REQ_TEST_CLEAR: begin
                        flag_write        = 1'b1;
                        rsp_item.flag_hit = |(rd_data_ff & mask);
                     end
                     REQ_IS_SET: begin
                        rsp_item.flag_hit = |(rd_data_ff & mask);
                     end
                     REQ_ANY: begin
                        rsp_item.flag_hit = cur_nz != '0;
                     end
                     REQ_SNAPSHOT: begin
                        rsp_item.bank_word  = rd_data_ff;
                        rsp_item.word_index = 12'(idx_ff);
                        rsp_item.final_item = is_last;
                        if (!is_last) begin
                           idx_in    = idx_ff + CNT_W'(1);
                           mem_re    = 1'b1;
                           mem_raddr = {cmd_ff.cls, BANK_W'(idx_ff + CNT_W'(1))};
                           state_in  = ST_EXEC;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (flag_write) begin
                  mem_we    = 1'b1;
                  mem_waddr = {cmd_ff.cls, cmd_ff.bank};
                  mem_wdata = new_word;
                  if (rd_data_ff == 16'd0 && new_word != 16'd0) begin
                     nz_cnt_in[cmd_ff.cls] = cur_nz + NZ_W'(1);
                  end else if (rd_data_ff != 16'd0 && new_word == 16'd0) begin
                     nz_cnt_in[cmd_ff.cls] = cur_nz - NZ_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_WIPE;
         wipe_ff    <= '0;
         last_id_ff <= {CLASS_COUNT{NO_ID}};
         nz_cnt_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         wipe_ff    <= wipe_in;
         last_id_ff <= last_id_in;
         nz_cnt_ff  <= nz_cnt_in;
      end
   end

endmodule

// ===== hdl/sfbr_rsp_queue.sv =====
// Two-entry result queue that parts the back end from the result channel.
// Depends on sfbr_pkg.
`timescale 1ns / 1ps

module sfbr_rsp_queue import sfbr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type item_in,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output rsp_type item_out
);

   rsp_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign item_out = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = 2'(cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok});
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== hdl/status_flag_bank_register.sv =====
// Top level of the sticky status flag bank: front end, back end and result queue.
// Depends on sfbr_pkg, sfbr_front, sfbr_back and sfbr_rsp_queue.
//
//   channel   handshake           word fields
//   request   req_push / req_full req_type, req_status_class, req_flag_id, req_snapshot_len
//   result    rsp_pop / rsp_empty rsp_flag_hit, rsp_recent_id, rsp_bank_word,
//                                 rsp_word_index, rsp_final_item, rsp_error_code
//
// Single-flag, any, read-last and error requests pass the back end as
// one flag memory read, then the write and the result.
// A snapshot returns each word while reading the next; clear-all zeroes the class first.
// After reset a wipe pass clears all of the flag memory;
// req_full stays high meanwhile.
// A full result queue stalls the back end; the two-entry command queue accepts until full.
`timescale 1ns / 1ps

module status_flag_bank_register import sfbr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_type,
   input  logic [1:0]  req_status_class,
   input  logic [15:0] req_flag_id,
   input  logic [15:0] req_snapshot_len,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic        rsp_flag_hit,
   output logic [15:0] rsp_recent_id,
   output logic [15:0] rsp_bank_word,
   output logic [11:0] rsp_word_index,
   output logic        rsp_final_item,
   output logic [1:0]  rsp_error_code
);

   cmd_link_type  cmd_link;
   back_ctrl_type back_ctrl;
   logic          q_full;
   logic          q_push;
   rsp_type       q_item_in;
   rsp_type       q_item_out;

   sfbr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_type         (req_type),
      .req_status_class (req_status_class),
      .req_flag_id      (req_flag_id),
      .req_snapshot_len (req_snapshot_len),
      .back_ctrl        (back_ctrl),
      .cmd_link         (cmd_link)
   );

   sfbr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_link  (cmd_link),
      .back_ctrl (back_ctrl),
      .rsp_full  (q_full),
      .rsp_push  (q_push),
      .rsp_item  (q_item_in)
   );

   sfbr_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_item_in),
      .full     (q_full),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .item_out (q_item_out)
   );

   assign rsp_flag_hit   = q_item_out.flag_hit;
   assign rsp_recent_id  = q_item_out.recent_id;
   assign rsp_bank_word  = q_item_out.bank_word;
   assign rsp_word_index = q_item_out.word_index;
   assign rsp_final_item = q_item_out.final_item;
   assign rsp_error_code = q_item_out.error_code;

endmodule

// ===== hdl/sfbr_checker.sv =====
// Port-level checks on the status flag bank, bound to the top level.
// Depends on sfbr_pkg, assert_macros.svh and status_flag_bank_register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfbr_checker import sfbr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_flag_hit,
   input logic [15:0] rsp_recent_id,
   input logic [15:0] rsp_bank_word,
   input logic        rsp_final_item,
   input logic [1:0]  rsp_error_code
);

   `SFBR_ASSERT(a_wipe_after_reset, clock, reset |=> req_full, "request side open during wipe")
   `SFBR_ASSERT(a_empty_after_reset, clock, reset |=> rsp_empty, "result left after reset")
   `SFBR_ASSERT_RST(a_err_final, clock, reset, (!rsp_empty && rsp_error_code != ERR_OK) |-> rsp_final_item, "error word not final")
   `SFBR_ASSERT_RST(a_class_none, clock, reset, (!rsp_empty && rsp_error_code == ERR_CLASS) |-> (rsp_recent_id == NO_ID && !rsp_flag_hit), "bad class word carries data")
   `SFBR_ASSERT_RST(a_word_ok, clock, reset, (!rsp_empty && rsp_bank_word != 16'd0) |-> (rsp_error_code == ERR_OK && !rsp_flag_hit), "bank word on wrong result")

endmodule

bind status_flag_bank_register sfbr_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_flag_hit   (rsp_flag_hit),
   .rsp_recent_id  (rsp_recent_id),
   .rsp_bank_word  (rsp_bank_word),
   .rsp_final_item (rsp_final_item),
   .rsp_error_code (rsp_error_code)
);
